FILE: hw/rtl/mbrtu_pkg.sv
package mbrtu_pkg;

  localparam int BUFFER_DEPTH  = 64;
  localparam int MIN_FRAME_LEN = 4;

  localparam int BUF_AW = $clog2(BUFFER_DEPTH);
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int DLEN_W = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] STATION_ADDRESS_RESET = 8'd1;

  localparam logic [0:0] REG_STATION_ADDRESS = 1'b0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_CRC   = 2'd2,
    ST_ADDR  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_EVAL,
    S_READ,
    S_LOAD
  } rx_state_t;

endpackage

FILE: hw/rtl/modbus_rtu_frame_receiver_top.sv
// Modbus RTU frame receiver. Bytes arrive on the s_ side with s_tuser low; each stored byte
// is folded into the CRC-16/MODBUS one bit per clock, and no new request is taken until
// that byte's bit steps are done. Bytes past the 64-entry frame store are accepted and
// dropped. A request with s_tuser high closes the frame: an evaluation state, then either a
// single fault result (too short, crc bad, not addressed) or the function code and data bytes
// with m_tlast on the final one; each payload byte passes a read and a load state because the
// frame store has one registered read port. Count and CRC clear as the evaluation completes;
// after the last result the block takes the next request while that result may still wait
// in the output register. The station address register sits at byte address 0 of the APB
// port (reset value 1). The store needs no clearing pass after reset.
module modbus_rtu_frame_receiver_top
  import mbrtu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // received bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic        s_tuser,   // frame_end
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status[1:0], payload_byte[9:2], data_length[15:10]
  output logic        m_tlast    // last
);

  rx_state_t state, state_next;

  logic [7:0]        station_address;
  logic [CNT_W-1:0]  byte_count;
  logic [15:0]       running_crc;
  logic [2:0]        bit_cnt;
  logic [7:0]        addr_byte;
  logic [BUF_AW-1:0] rd_idx;
  logic [BUF_AW-1:0] last_idx;
  logic [DLEN_W-1:0] dlen;
  logic [7:0]        rd_data;
  logic [7:0]        frame_store [BUFFER_DEPTH];

  status_t           out_status;
  logic [7:0]        out_payload;
  logic [DLEN_W-1:0] out_len;

  logic    in_acc;
  logic    store_wr;
  logic    out_free;
  status_t eval_status;
  logic    load_fault;
  logic    load_ok;
  logic    byte_last;
  logic    cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_STATION_ADDRESS);
  assign prdata   = (paddr[2] == REG_STATION_ADDRESS) ? {24'd0, station_address} : 32'd0;

  assign m_tdata  = {out_len, out_payload, out_status};

  assign out_free = !m_tvalid || m_tready;
  assign byte_last = (rd_idx == last_idx);

  always_comb begin
    if (byte_count < CNT_W'(MIN_FRAME_LEN)) begin
      eval_status = ST_SHORT;
    end else if (running_crc != 16'd0) begin
      eval_status = ST_CRC;
    end else if (addr_byte != station_address) begin
      eval_status = ST_ADDR;
    end else begin
      eval_status = ST_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser) begin
            state_next = S_EVAL;
          end else if (byte_count < CNT_W'(BUFFER_DEPTH)) begin
            state_next = S_CRC;
          end
        end
      end
      S_CRC: begin
        if (bit_cnt == 3'd7) begin
          state_next = S_IDLE;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          state_next = (eval_status == ST_OK) ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          state_next = byte_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs and strobes
  always_comb begin
    s_tready   = (state == S_IDLE);
    in_acc     = s_tvalid && s_tready;
    store_wr   = in_acc && !s_tuser && (byte_count < CNT_W'(BUFFER_DEPTH));
    load_fault = (state == S_EVAL) && out_free && (eval_status != ST_OK);
    load_ok    = (state == S_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= STATION_ADDRESS_RESET;
    end else if (cfg_wr) begin
      station_address <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_crc <= CRC_INIT;
      bit_cnt     <= '0;
    end else begin
      if (store_wr) begin
        byte_count  <= byte_count + CNT_W'(1);
        running_crc <= running_crc ^ {8'd0, s_tdata};
        bit_cnt     <= '0;
      end else if (state == S_CRC) begin
        running_crc <= running_crc[0] ? ((running_crc >> 1) ^ CRC_POLY) : (running_crc >> 1);
        bit_cnt     <= bit_cnt + 3'd1;
      end else if ((state == S_EVAL) && out_free) begin
        byte_count  <= '0;
        running_crc <= CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      frame_store[byte_count[BUF_AW-1:0]] <= s_tdata;
      if (byte_count == '0) begin
        addr_byte <= s_tdata;
      end
    end
    rd_data <= frame_store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if ((state == S_EVAL) && out_free) begin
      rd_idx   <= BUF_AW'(1);
      last_idx <= BUF_AW'(byte_count - CNT_W'(3));
      dlen     <= DLEN_W'(byte_count - CNT_W'(4));
    end else if (load_ok && !byte_last) begin
      rd_idx <= rd_idx + BUF_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_fault || load_ok) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fault) begin
      out_status  <= eval_status;
      out_payload <= 8'd0;
      out_len     <= '0;
      m_tlast     <= 1'b1;
    end else if (load_ok) begin
      out_status  <= ST_OK;
      out_payload <= rd_data;
      out_len     <= dlen;
      m_tlast     <= byte_last;
    end
  end

`ifndef ASSERT_OFF
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser && (byte_count < CNT_W'(BUFFER_DEPTH)))
      |=> (byte_count == $past(byte_count) + CNT_W'(1)))
    else $error("byte count did not advance on a stored byte");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(BUFFER_DEPTH))
    else $error("byte count beyond frame store depth");

  a_fault_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status != ST_OK))
      |-> (out_payload == 8'd0 && out_len == '0 && m_tlast))
    else $error("fault result carries payload or lacks last");

  a_eval_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EVAL) && out_free)
      |=> (byte_count == '0 && running_crc == CRC_INIT))
    else $error("frame state not cleared after evaluation");
`endif

endmodule

FILE: sim/modbus_rtu_frame_receiver_top_test.sv
module modbus_rtu_frame_receiver_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrtu_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_ITEMS   = 40;
  localparam logic [2:0] STATION_OFFSET = 3'({REG_STATION_ADDRESS, 2'b00});

  typedef enum logic [2:0] {
    K_BYTE,
    K_FILL,
    K_CRC_LO,
    K_CRC_HI,
    K_CRC_BAD,
    K_END
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] val;
    logic [6:0] reps;
    logic       typed;
    status_t    st;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       fe;
    logic       typed;
    status_t    st;
  } rx_req_t;

  typedef struct packed {
    status_t    st;
    logic [7:0] pay;
    logic [5:0] dlen;
    logic       last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // rx_byte[7:0]
  logic        s_tuser = 1'b0; // frame_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // status[1:0], payload_byte[9:2], data_length[15:10]
  logic        m_tlast;        // last

  modbus_rtu_frame_receiver_top u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  stim_row_t directed_rows [36] = '{
    // empty frame
    '{K_END,     8'hA5, 7'd1,  1'b1, ST_SHORT},
    // three bytes only
    '{K_BYTE,    8'h01, 7'd1,  1'b0, ST_OK},
    '{K_BYTE,    8'hFF, 7'd2,  1'b0, ST_OK},
    '{K_END,     8'h5A, 7'd1,  1'b1, ST_SHORT},
    // shortest good frame
    '{K_BYTE,    8'h01, 7'd1,  1'b0, ST_OK},
    '{K_BYTE,    8'hFF, 7'd1,  1'b0, ST_OK},
    '{K_CRC_LO,  8'h00, 7'd1,  1'b0, ST_OK},
    '{K_CRC_HI,  8'h00, 7'd1,  1'b0, ST_OK},
    '{K_END,     8'hFF, 7'd1,  1'b0, ST_OK},
    // good frame with data extremes
    '{K_BYTE,    8'h01, 7'd1,  1'b0, ST_OK},
    '{K_BYTE,    8'h00, 7'd2,  1'b0, ST_OK},
    '{K_BYTE,    8'hFF, 7'd1,  1'b0, ST_OK},
    '{K_CRC_LO,  8'h00, 7'd1,  1'b0, ST_OK},
    '{K_CRC_HI,  8'h00, 7'd1,  1'b0, ST_OK},
    '{K_END,     8'h00, 7'd1,  1'b0, ST_OK},
    // corrupted crc
    '{K_BYTE,    8'h01, 7'd1,  1'b0, ST_OK},
    '{K_BYTE,    8'h06, 7'd1,  1'b0, ST_OK},
    '{K_CRC_LO,  8'h00, 7'd1,  1'b0, ST_OK},
    '{K_CRC_BAD, 8'h00, 7'd1,  1'b0, ST_OK},
    '{K_END,     8'h00, 7'd1,  1'b1, ST_CRC},
    // valid crc, other station
    '{K_BYTE,    8'h02, 7'd1,  1'b0, ST_OK},
    '{K_BYTE,    8'h03, 7'd1,  1'b0, ST_OK},
    '{K_CRC_LO,  8'h00, 7'd1,  1'b0, ST_OK},
    '{K_CRC_HI,  8'h00, 7'd1,  1'b0, ST_OK},
    '{K_END,     8'h00, 7'd1,  1'b1, ST_ADDR},
    // crc fault wins over address
    '{K_BYTE,    8'h80, 7'd1,  1'b0, ST_OK},
    '{K_BYTE,    8'h10, 7'd1,  1'b0, ST_OK},
    '{K_CRC_LO,  8'h00, 7'd1,  1'b0, ST_OK},
    '{K_CRC_BAD, 8'h00, 7'd1,  1'b0, ST_OK},
    '{K_END,     8'h00, 7'd1,  1'b1, ST_CRC},
    // full store, trailing bytes dropped
    '{K_BYTE,    8'h01, 7'd1,  1'b0, ST_OK},
    '{K_FILL,    8'h00, 7'd61, 1'b0, ST_OK},
    '{K_CRC_LO,  8'h00, 7'd1,  1'b0, ST_OK},
    '{K_CRC_HI,  8'h00, 7'd1,  1'b0, ST_OK},
    '{K_FILL,    8'h00, 7'd5,  1'b0, ST_OK},
    '{K_END,     8'h00, 7'd1,  1'b0, ST_OK}
  };

  // frame state as the block should hold it
  logic [7:0]    frame_bytes [BUFFER_DEPTH];
  int            stored_count = 0;
  logic [15:0]   frame_crc = CRC_INIT;
  logic [7:0]    station_addr = STATION_ADDRESS_RESET;

  rx_req_t       send_q [$];
  rx_req_t       cur_req;
  frame_result_t expected_results [$];
  logic [15:0]   gen_crc = CRC_INIT;
  int            queued_items = 0;
  int            results_seen = 0;
  int            mismatches = 0;
  int            cycle_count = 0;
  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;
  logic          rx_hold = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_fold(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    return x;
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $realtime, what);
  endfunction

  function automatic void absorb_request(rx_req_t r);
    frame_result_t outs [$];
    int n;
    int dlen;
    n = stored_count;
    if (!r.fe) begin
      if (stored_count < BUFFER_DEPTH) begin
        frame_bytes[stored_count] = r.rx;
        stored_count++;
        frame_crc = crc16_fold(frame_crc, r.rx);
      end
      return;
    end
    if (n < MIN_FRAME_LEN || n < 4) begin
      outs.push_back('{ST_SHORT, 8'h00, 6'd0, 1'b1});
    end else if (frame_crc != 16'h0000) begin
      outs.push_back('{ST_CRC, 8'h00, 6'd0, 1'b1});
    end else if (frame_bytes[0] != station_addr) begin
      outs.push_back('{ST_ADDR, 8'h00, 6'd0, 1'b1});
    end else begin
      dlen = n - 4;
      for (int k = 0; k <= dlen; k++)
        outs.push_back('{ST_OK, frame_bytes[k + 1], 6'(dlen), k == dlen});
    end
    if (r.typed) expected_results.push_back('{r.st, 8'h00, 6'd0, 1'b1});
    else foreach (outs[i]) expected_results.push_back(outs[i]);
    stored_count = 0;
    frame_crc = CRC_INIT;
  endfunction

  function automatic void queue_raw(logic [7:0] b, logic fe, logic typed, status_t st);
    send_q.push_back('{b, fe, typed, st});
    queued_items++;
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    queue_raw(b, 1'b0, 1'b0, ST_OK);
    gen_crc = crc16_fold(gen_crc, b);
  endfunction

  function automatic void queue_end(logic typed, status_t st);
    queue_raw(8'($urandom), 1'b1, typed, st);
    gen_crc = CRC_INIT;
  endfunction

  function automatic void queue_random_frame();
    int pick;
    int len;
    logic [7:0] addr;
    pick = $urandom_range(0, 99);
    addr = station_addr;
    if (pick < 8) begin
      repeat ($urandom_range(0, MIN_FRAME_LEN - 1)) queue_byte(8'($urandom));
      queue_end(1'b0, ST_OK);
      return;
    end
    if (pick < 18) addr = station_addr ^ 8'($urandom_range(1, 255));
    if (pick >= 96) len = BUFFER_DEPTH - 4;
    else if (pick >= 90) len = $urandom_range(9, BUFFER_DEPTH - 4);
    else len = $urandom_range(0, 8);
    queue_byte(addr);
    repeat (len + 1) queue_byte(8'($urandom));
    queue_raw(gen_crc[7:0], 1'b0, 1'b0, ST_OK);
    if (pick >= 18 && pick < 28)
      queue_raw(gen_crc[15:8] ^ (8'h01 << $urandom_range(0, 7)), 1'b0, 1'b0, ST_OK);
    else
      queue_raw(gen_crc[15:8], 1'b0, 1'b0, ST_OK);
    if (pick >= 96) repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
    queue_end(1'b0, ST_OK);
  endfunction

  // byte sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_request(cur_req);
      if (!s_tvalid || s_tready) begin
        if (send_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          cur_req = send_q.pop_front();
          s_tdata <= cur_req.rx;
          s_tuser <= cur_req.fe;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{status_t'(m_tdata[1:0]), m_tdata[9:2], m_tdata[15:10], m_tlast};
      results_seen++;
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("result %0d with nothing pending: st=%0d pay=%h len=%0d last=%b",
                                results_seen, got.st, got.pay, got.dlen, got.last));
      end else begin
        want = expected_results.pop_front();
        if (got.st !== want.st || got.pay !== want.pay || got.dlen !== want.dlen ||
            got.last !== want.last)
          note_mismatch($sformatf(
            "result %0d: want st=%0d pay=%h len=%0d last=%b, got st=%0d pay=%h len=%0d last=%b",
            results_seen, want.st, want.pay, want.dlen, want.last,
            got.st, got.pay, got.dlen, got.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("modbus_rtu_frame_receiver_top_test: errors");
      $finish;
    end
  end

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= STATION_OFFSET;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_station(input logic [7:0] addr);
    logic [31:0] rd;
    apb_access(1'b1, {24'h0, addr}, rd);
    station_addr = addr;
    apb_access(1'b0, 32'h0, rd);
    if (rd !== {24'h0, addr})
      note_mismatch($sformatf("station_address reads %h after writing %h", rd, addr));
  endtask

  task automatic drain();
    do @(negedge clk);
    while (send_q.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] addr, input int tx_pct, input int rx_pct);
    int start;
    drain();
    set_station(addr);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    start = queued_items;
    while (queued_items - start < PHASE_ITEMS) queue_random_frame();
  endtask

  initial begin
    logic [31:0] rd;
    stim_row_t row;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    apb_access(1'b0, 32'h0, rd);
    if (rd !== {24'h0, STATION_ADDRESS_RESET})
      note_mismatch($sformatf("station_address reads %h after reset", rd));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        K_BYTE:    repeat (row.reps) queue_byte(row.val);
        K_FILL:    repeat (row.reps) queue_byte(8'($urandom));
        K_CRC_LO:  queue_raw(gen_crc[7:0], 1'b0, 1'b0, ST_OK);
        K_CRC_HI:  queue_raw(gen_crc[15:8], 1'b0, 1'b0, ST_OK);
        K_CRC_BAD: queue_raw(gen_crc[15:8] ^ 8'h01, 1'b0, 1'b0, ST_OK);
        default:   queue_end(row.typed, row.st);
      endcase
    end

    // lowest address, no idling, long output stall to back up the input
    run_phase(8'h00, 0, 0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    run_phase(8'hFF, 64, 0);
    run_phase(8'($urandom), 0, 64);
    run_phase(8'($urandom_range(1, 254)), 10, 10);
    run_phase(STATION_ADDRESS_RESET, 0, 0);
    drain();

    if (mismatches == 0) begin
      $display("modbus_rtu_frame_receiver_top_test: clean");
    end else begin
      $display("modbus_rtu_frame_receiver_top_test: errors");
    end
    $finish;
  end

endmodule
